FILE: rtl/core/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int CAPACITY     = 64;
    localparam int PRIO_BITS    = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef struct packed {
        logic                           used;
        logic signed [PRIO_BITS-1:0]    prio;
        logic        [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic                           enq;
        logic                           deq;
        logic signed [PRIO_BITS-1:0]    prio;
        logic        [PAYLOAD_BITS-1:0] payload;
    } cmd_t;

endpackage

FILE: rtl/core/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded stable priority queue built as a chain of sorting cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind selects enqueue or dequeue; an
// enqueue carries prio and payload, placed after every stored entry of equal
// or smaller priority, so ties leave in arrival order.
// Output channel (out_valid / out_stall): one result item per input item with
// status, removed_payload, head_valid, head_prio and count after the item.
// Every cell compares against the new priority in parallel and all cells
// move on the same edge, so one item is taken each cycle unless stalled.
// The result sits in an output register; while it is stalled, in_stall is
// raised and the queue holds.
// Reset clears every cell's used bit and the count; the queue is empty and
// accepts an item as soon as reset is released.
// An enqueue into a full queue reports ST_FULL and is dropped; a dequeue on
// an empty queue reports ST_EMPTY and returns payload 0.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic signed [ssq_pkg::PRIO_BITS-1:0]    prio,
    input  logic        [ssq_pkg::PAYLOAD_BITS-1:0] payload,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [ssq_pkg::PAYLOAD_BITS-1:0]  removed_payload,
    output logic                              head_valid,
    output logic signed [ssq_pkg::PRIO_BITS-1:0]    head_prio,
    output logic [ssq_pkg::COUNT_BITS-1:0]    count
);
    import ssq_pkg::*;

    entry_t                  ent      [CAPACITY];
    entry_t                  ent_next [CAPACITY];
    logic                    le       [CAPACITY];
    cmd_t                    cmd;
    logic                    accept;
    logic                    is_full;
    logic                    is_empty;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic                    out_valid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic [PAYLOAD_BITS-1:0] removed_reg;
    logic [PAYLOAD_BITS-1:0] removed_next;
    logic                    head_valid_reg;
    logic signed [PRIO_BITS-1:0] head_prio_reg;
    logic signed [PRIO_BITS-1:0] head_prio_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_full  = (count_reg == COUNT_BITS'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        cmd.enq      = accept && (kind == KIND_ENQ) && !is_full;
        cmd.deq      = accept && (kind == KIND_DEQ) && !is_empty;
        cmd.prio     = prio;
        cmd.payload  = payload;
        count_next   = count_reg;
        status_next  = ST_DONE;
        removed_next = '0;
        if (cmd.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.deq)
        begin
            count_next   = count_reg - 1'b1;
            removed_next = ent[0].payload;
        end
        else if (kind == KIND_ENQ)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_EMPTY;
        end
        head_prio_next = ent_next[0].used ? ent_next[0].prio : '0;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_le_w;
        if (i == 0)
        begin : g_first
            assign left_e    = '0;
            assign left_le_w = 1'b1;
        end
        else
        begin : g_mid
            assign left_e    = ent[i-1];
            assign left_le_w = le[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = ent[i+1];
        end

        ssq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_le     (left_le_w),
            .right_entry (right_e),
            .entry       (ent[i]),
            .entry_next  (ent_next[i]),
            .le          (le[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            removed_reg    <= removed_next;
            head_valid_reg <= ent_next[0].used;
            head_prio_reg  <= head_prio_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign removed_payload = removed_reg;
    assign head_valid      = head_valid_reg;
    assign head_prio       = head_prio_reg;
    assign count           = count_reg;

endmodule

FILE: rtl/core/ssq_cell.sv
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: holds, takes the new item, or shifts.
// ----------------------------------------------------------------------------
module ssq_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  ssq_pkg::cmd_t   cmd,
    input  ssq_pkg::entry_t left_entry,
    input  logic           left_le,
    input  ssq_pkg::entry_t right_entry,
    output ssq_pkg::entry_t entry,
    output ssq_pkg::entry_t entry_next,
    output logic           le
);
    import ssq_pkg::*;

    logic                    used_reg;
    logic signed [PRIO_BITS-1:0]    prio_reg;
    logic        [PAYLOAD_BITS-1:0] payload_reg;

    assign entry.used    = used_reg;
    assign entry.prio    = prio_reg;
    assign entry.payload = payload_reg;

    assign le = used_reg && ($signed(prio_reg) <= $signed(cmd.prio));

    always_comb
    begin
        entry_next = entry;
        if (cmd.enq)
        begin
            if (!le)
            begin
                if (left_le)
                begin
                    entry_next.used    = 1'b1;
                    entry_next.prio    = cmd.prio;
                    entry_next.payload = cmd.payload;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
        end
        else if (cmd.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= entry_next.used;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= entry_next.prio;
        payload_reg <= entry_next.payload;
    end

endmodule

FILE: rtl/core/ssq_checker.sv
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks of the stable sorted priority queue.
// ----------------------------------------------------------------------------
module ssq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [1:0]                        status,
    input logic [ssq_pkg::PAYLOAD_BITS-1:0]  removed_payload,
    input logic                              head_valid,
    input logic [ssq_pkg::PRIO_BITS-1:0]     head_prio,
    input logic [ssq_pkg::COUNT_BITS-1:0]    count
);
    import ssq_pkg::*;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item gave no result");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(count)
            && $stable(head_prio) && $stable(removed_payload))
        else $error("stalled result changed");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (count != '0))
            && (head_valid || head_prio == '0))
        else $error("head does not match count");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0 && removed_payload == '0)
        else $error("empty dequeue reported wrongly");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == COUNT_BITS'(CAPACITY)
            && removed_payload == '0)
        else $error("dropped enqueue on a queue that is not full");

endmodule

bind stable_sorted_priority_queue ssq_checker u_ssq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .removed_payload (removed_payload),
    .head_valid      (head_valid),
    .head_prio       (head_prio),
    .count           (count)
);
